### src/acfl_pkg.sv
// Shared types and constants for the actuator fade and lockout block.
// Used by every module under src; depends on nothing.
package acfl_pkg;

    localparam int CLOCK_BITS_DEF = 17;

    localparam int LEVEL_W    = 8;
    localparam int TARGET_W   = 8;
    localparam int DURATION_W = 16;
    localparam int DRIVE_W    = 12;
    localparam int Q_W        = 16;
    localparam int MAX_ON_W   = 16;
    localparam int MIN_OFF_W  = 16;
    localparam int MAX_LVL_W  = 8;
    localparam int SCALE_W    = 12;
    localparam int FINE_SHIFT = 4;

    localparam int DIV_W     = 32;
    localparam int DIVISOR_W = 16;

    // (x + 1) * DRIVE_RECIP >> RCP_SHIFT equals x / 255 for every x below 2**24.
    localparam int               DRIVE_X_W   = 21;
    localparam int               RCP_W       = 17;
    localparam int               RCP_SHIFT   = 24;
    localparam logic [RCP_W-1:0] DRIVE_RECIP = 17'h10101;

    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 24;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_MAX_ON     = 2'd0;
    localparam logic [1:0] REG_MIN_OFF    = 2'd1;
    localparam logic [1:0] REG_MAX_LEVEL  = 2'd2;
    localparam logic [1:0] REG_FINE_SCALE = 2'd3;

    localparam logic [MAX_ON_W-1:0]  MAX_ON_RST    = 16'd2000;
    localparam logic [MIN_OFF_W-1:0] MIN_OFF_RST   = 16'd8000;
    localparam logic [MAX_LVL_W-1:0] MAX_LEVEL_RST = 8'd255;
    localparam logic                 FINE_RST      = 1'b0;

    typedef struct packed {
        logic load_in;
        logic cmd_store;
        logic tick_update;
        logic fade_mul;
        logic div_start;
        logic fade_commit;
        logic drive_mul;
        logic out_load;
    } acfl_cmd_t;

    typedef struct packed {
        logic is_cmd;
        logic need_div;
        logic div_done;
        logic out_busy;
    } acfl_status_t;

endpackage

### src/acfl_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on acfl_pkg for its default widths.
module acfl_div #(
    parameter int DIV_W     = acfl_pkg::DIV_W,
    parameter int DIVISOR_W = acfl_pkg::DIVISOR_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [DIV_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;
    logic                 last;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign last  = cnt_reg == CNT_W'(DIV_W - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : trial[DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### src/acfl_dp.sv
// Datapath: level and counter state, fade and drive arithmetic, output register.
// Depends on acfl_pkg and acfl_div.
module acfl_dp #(
    parameter int CLOCK_BITS = acfl_pkg::CLOCK_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  acfl_pkg::acfl_cmd_t                 cmd,
    output acfl_pkg::acfl_status_t              status,
    input  logic [acfl_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [acfl_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic [acfl_pkg::MAX_ON_W-1:0]       max_on,
    input  logic [acfl_pkg::MIN_OFF_W-1:0]      min_off,
    input  logic [acfl_pkg::MAX_LVL_W-1:0]      max_level,
    input  logic                                fine_scale,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [acfl_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int Q_W   = acfl_pkg::Q_W;
    localparam int CB_W  = CLOCK_BITS;
    localparam int DX_W  = acfl_pkg::DRIVE_X_W;
    localparam int RCP_W = acfl_pkg::RCP_W;

    logic                              action_reg;
    logic [acfl_pkg::TARGET_W-1:0]     target_reg;
    logic [acfl_pkg::DURATION_W-1:0]   duration_reg;

    logic [Q_W-1:0]                    level_q_reg, level_q_next;
    logic [Q_W-1:0]                    start_q_reg, start_q_next;
    logic [acfl_pkg::TARGET_W-1:0]     goal_reg, goal_next;
    logic [acfl_pkg::DURATION_W-1:0]   span_reg, span_next;
    logic [CB_W-1:0]                   fade_reg, fade_next;
    logic [CB_W-1:0]                   on_reg, on_next;
    logic [CB_W-1:0]                   off_reg, off_next;
    logic                              lock_reg, lock_next;
    logic                              neg_reg;
    logic [acfl_pkg::DIV_W-1:0]        prod_reg;

    logic                              out_valid_reg, out_valid_next;
    logic [acfl_pkg::LEVEL_W-1:0]      out_level_reg;
    logic [acfl_pkg::DRIVE_W-1:0]      out_drive_reg;
    logic                              out_locked_reg;

    logic [CB_W-1:0]                   fade_bump, on_bump, off_bump;
    logic                              on_over, off_over, need_div;
    logic [Q_W-1:0]                    goal_q, diff_mag, fade_level, commit_level;
    logic                              diff_neg;
    logic [acfl_pkg::DIV_W-1:0]        fade_prod, drive_prod;
    logic [acfl_pkg::SCALE_W-1:0]      scale_m;
    logic [DX_W-1:0]                   drive_x;
    logic [DX_W+RCP_W-1:0]             drive_rcp;
    logic [acfl_pkg::DIVISOR_W-1:0]    div_divisor;
    logic [acfl_pkg::DIV_W-1:0]        quotient;
    logic                              div_done;

    assign fade_bump = (fade_reg == '1) ? fade_reg : fade_reg + 1'b1;
    assign on_bump   = (on_reg == '1) ? on_reg : on_reg + 1'b1;
    assign off_bump  = (off_reg == '1) ? off_reg : off_reg + 1'b1;
    assign on_over   = on_bump > {{(CB_W - acfl_pkg::MAX_ON_W){1'b0}}, max_on};
    assign off_over  = off_bump > {{(CB_W - acfl_pkg::MIN_OFF_W){1'b0}}, min_off};
    assign need_div  = !lock_reg
                    && ({{(CB_W - acfl_pkg::DURATION_W){1'b0}}, span_reg} > fade_reg);

    assign goal_q     = {goal_reg, 8'h00};
    assign diff_neg   = start_q_reg > goal_q;
    assign diff_mag   = diff_neg ? start_q_reg - goal_q : goal_q - start_q_reg;
    assign fade_prod  = {16'h0000, diff_mag} * {16'h0000, fade_reg[Q_W-1:0]};
    assign fade_level = neg_reg ? start_q_reg - quotient[Q_W-1:0]
                                : start_q_reg + quotient[Q_W-1:0];
    assign commit_level = lock_reg ? level_q_reg : (need_div ? fade_level : goal_q);

    assign scale_m    = fine_scale ? {max_level, {acfl_pkg::FINE_SHIFT{1'b0}}}
                                   : {{acfl_pkg::FINE_SHIFT{1'b0}}, max_level};
    assign drive_prod = {24'h000000, level_q_reg[Q_W-1:8]} * {20'h00000, scale_m};
    assign drive_x    = {1'b0, prod_reg[DX_W-2:0]} + {{(DX_W - 1){1'b0}}, 1'b1};
    assign drive_rcp  = {{RCP_W{1'b0}}, drive_x} * {{DX_W{1'b0}}, acfl_pkg::DRIVE_RECIP};
    assign div_divisor = span_reg;

    acfl_div #(
        .DIV_W     (acfl_pkg::DIV_W),
        .DIVISOR_W (acfl_pkg::DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        level_q_next = level_q_reg;
        start_q_next = start_q_reg;
        goal_next    = goal_reg;
        span_next    = span_reg;
        fade_next    = fade_reg;
        on_next      = on_reg;
        off_next     = off_reg;
        lock_next    = lock_reg;
        if (cmd.cmd_store)
        begin
            goal_next    = target_reg;
            span_next    = duration_reg;
            start_q_next = level_q_reg;
            fade_next    = '0;
        end
        if (cmd.tick_update)
        begin
            fade_next = fade_bump;
            on_next   = on_bump;
            if (on_over)
            begin
                level_q_next = '0;
                off_next     = '0;
                lock_next    = 1'b1;
            end
            else
            begin
                off_next = off_bump;
                if (lock_reg && off_over)
                begin
                    lock_next = 1'b0;
                end
            end
        end
        if (cmd.fade_commit)
        begin
            level_q_next = commit_level;
            if (commit_level == '0)
            begin
                on_next = '0;
            end
        end
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_q_reg   <= '0;
            start_q_reg   <= '0;
            goal_reg      <= '0;
            span_reg      <= '0;
            fade_reg      <= '0;
            on_reg        <= '0;
            off_reg       <= '0;
            lock_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_q_reg   <= level_q_next;
            start_q_reg   <= start_q_next;
            goal_reg      <= goal_next;
            span_reg      <= span_next;
            fade_reg      <= fade_next;
            on_reg        <= on_next;
            off_reg       <= off_next;
            lock_reg      <= lock_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            action_reg   <= s_tuser[0];
            target_reg   <= s_tdata[7:0];
            duration_reg <= s_tdata[23:8];
        end
        if (cmd.fade_mul)
        begin
            prod_reg <= fade_prod;
            neg_reg  <= diff_neg;
        end
        else if (cmd.drive_mul)
        begin
            prod_reg <= drive_prod;
        end
        if (cmd.out_load)
        begin
            out_level_reg  <= level_q_reg[Q_W-1:8];
            out_drive_reg  <= drive_rcp[acfl_pkg::RCP_SHIFT +: acfl_pkg::DRIVE_W];
            out_locked_reg <= lock_reg;
        end
    end

    assign status.is_cmd   = action_reg;
    assign status.need_div = need_div;
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_locked_reg, out_drive_reg, out_level_reg};

endmodule

### src/acfl_ctrl.sv
// Controller state machine that sequences one item through the datapath.
// Depends on acfl_pkg for the command and status structs.
module acfl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  acfl_pkg::acfl_status_t status,
    output acfl_pkg::acfl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DECIDE,
        ST_FADE_MUL,
        ST_FADE_GO,
        ST_FADE_WAIT,
        ST_COMMIT,
        ST_DRIVE_MUL,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.is_cmd)
                begin
                    cmd.cmd_store = 1'b1;
                    state_next    = ST_DRIVE_MUL;
                end
                else
                begin
                    cmd.tick_update = 1'b1;
                    state_next      = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = status.need_div ? ST_FADE_MUL : ST_COMMIT;
            end
            ST_FADE_MUL:
            begin
                cmd.fade_mul = 1'b1;
                state_next   = ST_FADE_GO;
            end
            ST_FADE_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_FADE_WAIT;
            end
            ST_FADE_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.fade_commit = 1'b1;
                state_next      = ST_DRIVE_MUL;
            end
            ST_DRIVE_MUL:
            begin
                cmd.drive_mul = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/actuator_fade_with_lockout.sv
// Top level of the actuator fade and lockout block: register file and wiring.
// Depends on acfl_pkg, acfl_ctrl, acfl_dp and acfl_div.
//
//   channel  signals                          direction  carries
//   config   psel penable pwrite paddr ...    in/out     four registers at 0x0..0xC
//   s        s_tvalid s_tready s_tdata s_tuser in        one tick or fade command
//   m        m_tvalid m_tready m_tdata        out        level, drive, lockout flag
//
// A fade command passes the update, drive multiply and finish states; a tick without an
// active fade also passes decide and commit, and a tick during a fade adds the fade
// multiply and divide, on the radix-2 divider. The drive uses a reciprocal multiply.
// Reset clears all level, counter and lockout state; no clearing pass follows.
// A finished result waits in the output register while the next item is taken;
// a result that is ready while that register is still full stalls the block.
module actuator_fade_with_lockout #(
    parameter int CLOCK_BITS = acfl_pkg::CLOCK_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [acfl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [acfl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [acfl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: target[7:0], duration[23:8].
    input  logic [acfl_pkg::S_TDATA_W-1:0]    s_tdata,
    // Fields from bit 0: action[0].
    input  logic [acfl_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: level[7:0], drive[19:8], locked[20], zero fill.
    output logic [acfl_pkg::M_TDATA_W-1:0]    m_tdata
);

    logic [acfl_pkg::MAX_ON_W-1:0]  max_on_reg;
    logic [acfl_pkg::MIN_OFF_W-1:0] min_off_reg;
    logic [acfl_pkg::MAX_LVL_W-1:0] max_level_reg;
    logic                           fine_reg;
    logic                           wr_en;
    logic [1:0]                     reg_idx;

    acfl_pkg::acfl_cmd_t    cmd;
    acfl_pkg::acfl_status_t status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_on_reg    <= acfl_pkg::MAX_ON_RST;
            min_off_reg   <= acfl_pkg::MIN_OFF_RST;
            max_level_reg <= acfl_pkg::MAX_LEVEL_RST;
            fine_reg      <= acfl_pkg::FINE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                acfl_pkg::REG_MAX_ON:     max_on_reg    <= pwdata[15:0];
                acfl_pkg::REG_MIN_OFF:    min_off_reg   <= pwdata[15:0];
                acfl_pkg::REG_MAX_LEVEL:  max_level_reg <= pwdata[7:0];
                acfl_pkg::REG_FINE_SCALE: fine_reg      <= pwdata[0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            acfl_pkg::REG_MAX_ON:     prdata = {16'h0000, max_on_reg};
            acfl_pkg::REG_MIN_OFF:    prdata = {16'h0000, min_off_reg};
            acfl_pkg::REG_MAX_LEVEL:  prdata = {24'h000000, max_level_reg};
            acfl_pkg::REG_FINE_SCALE: prdata = {31'h00000000, fine_reg};
            default:                  prdata = '0;
        endcase
    end

    acfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    acfl_dp #(
        .CLOCK_BITS (CLOCK_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .max_on     (max_on_reg),
        .min_off    (min_off_reg),
        .max_level  (max_level_reg),
        .fine_scale (fine_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### src/acfl_chk.sv
// Port-level checker for the actuator fade and lockout block, with its bind.
// Depends on acfl_pkg and binds to actuator_fade_with_lockout.
module acfl_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [acfl_pkg::M_TDATA_W-1:0] m_tdata
);

    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed before its transfer.");

    ap_lock_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[20] |-> m_tdata[7:0] == 8'h00)
        else $error("Level is nonzero while lockout is active.");

    ap_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7:0] == 8'h00 |-> m_tdata[19:8] == 12'h000)
        else $error("Drive is nonzero at level zero.");

    ap_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input taken while the previous item is still in work.");

endmodule

bind actuator_fade_with_lockout acfl_chk u_acfl_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
